FILE: hdl/pkwrl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkwrl_pkg
// Shared widths, defaults and transaction payload types of the per-key
// fixed-window rate limiter.
// ----------------------------------------------------------------------------
package pkwrl_pkg;

  localparam int KEY_W       = 31;
  localparam int TIME_W      = 32;
  localparam int LIMIT_W     = 16;
  localparam int OUT_CNT_W   = 16;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int COUNT_BITS_DEF    = 16;

  localparam logic [TIME_W-1:0] DEFAULT_WINDOW = TIME_W'(3600);

  typedef struct packed {
    logic [KEY_W-1:0]   user_key;
    logic [TIME_W-1:0]  now_seconds;
    logic [LIMIT_W-1:0] user_limit;
  } req_t;

  typedef struct packed {
    logic                 allowed;
    logic                 first_exceeded;
    logic [LIMIT_W-1:0]   applied_limit;
    logic [OUT_CNT_W-1:0] current_count;
    logic                 table_full;
  } rsp_t;

endpackage
`default_nettype wire

FILE: hdl/pkwrl_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkwrl_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface pkwrl_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface
`default_nettype wire

FILE: hdl/pkwrl_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkwrl_ram
// Single-clock RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module pkwrl_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: hdl/pkwrl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkwrl_ctrl
// Request sequencer: key table scan, entry allocation, window
// read-modify-write and result register.
// ----------------------------------------------------------------------------
module pkwrl_ctrl import pkwrl_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF,
  parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  parameter int WIN_W         = TIME_W + COUNT_BITS + LIMIT_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  pkwrl_chan_if.sink             in_req,
  pkwrl_chan_if.source           out_rsp,
  input  wire logic [TIME_W-1:0] window_seconds,
  output logic                   key_we,
  output logic      [IDX_W-1:0]  key_waddr,
  output logic      [KEY_W-1:0]  key_wdata,
  output logic                   key_re,
  output logic      [IDX_W-1:0]  key_raddr,
  input  wire logic [KEY_W-1:0]  key_rdata,
  output logic                   win_we,
  output logic      [IDX_W-1:0]  win_waddr,
  output logic      [WIN_W-1:0]  win_wdata,
  output logic                   win_re,
  output logic      [IDX_W-1:0]  win_raddr,
  input  wire logic [WIN_W-1:0]  win_rdata
);

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
  localparam logic [CNT_W-1:0]      FULL_CNT  = CNT_W'(TABLE_ENTRIES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [CNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]   slot_r, slot_nxt;
  logic [KEY_W-1:0]   key_r;
  logic [TIME_W-1:0]  now_r;
  logic [LIMIT_W-1:0] lim_r;
  logic               out_valid_r, out_valid_nxt;
  rsp_t               out_pay_r, out_pay_nxt;

  logic                  in_fire;
  logic                  out_free;
  logic                  hit;
  logic [TIME_W-1:0]     rd_start;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [LIMIT_W-1:0]    rd_lim;
  logic [TIME_W-1:0]     elapsed;
  logic                  restart;
  logic [TIME_W-1:0]     new_start;
  logic [COUNT_BITS-1:0] base_cnt;
  logic [COUNT_BITS-1:0] new_cnt;
  logic [LIMIT_W-1:0]    new_lim;
  logic                  bumped;
  logic [CMP_W-1:0]      cnt_ext;
  logic [CMP_W-1:0]      lim_ext;
  rsp_t                  upd_rsp;

  assign in_fire      = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == ST_IDLE);
  assign out_free     = !out_valid_r || out_rsp.ready;
  assign hit          = cmp_vld_r && (key_rdata == key_r);

  assign rd_start = win_rdata[WIN_W-1 -: TIME_W];
  assign rd_cnt   = win_rdata[LIMIT_W +: COUNT_BITS];
  assign rd_lim   = win_rdata[LIMIT_W-1:0];
  assign elapsed  = now_r - rd_start;
  assign restart  = (state_r == ST_MISS) || (elapsed >= window_seconds);

  assign new_start = restart ? now_r : rd_start;
  assign base_cnt  = restart ? '0 : rd_cnt;
  assign new_lim   = restart ? lim_r : rd_lim;
  assign bumped    = (base_cnt != COUNT_MAX);
  assign new_cnt   = bumped ? base_cnt + COUNT_BITS'(1) : base_cnt;
  assign cnt_ext   = CMP_W'(new_cnt);
  assign lim_ext   = CMP_W'(new_lim);

  always_comb begin
    upd_rsp                = '0;
    upd_rsp.allowed        = (cnt_ext < lim_ext);
    upd_rsp.first_exceeded = bumped && (cnt_ext == lim_ext);
    upd_rsp.applied_limit  = new_lim;
    upd_rsp.current_count  = cnt_ext[OUT_CNT_W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_pay_nxt   = out_pay_r;
    key_we        = 1'b0;
    key_waddr     = used_r[IDX_W-1:0];
    key_wdata     = key_r;
    key_re        = 1'b0;
    key_raddr     = scan_idx_r[IDX_W-1:0];
    win_we        = 1'b0;
    win_waddr     = slot_r;
    win_wdata     = {new_start, new_cnt, new_lim};
    win_re        = 1'b0;
    win_raddr     = cmp_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          scan_idx_nxt = '0;
          cmp_vld_nxt  = 1'b0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          win_re    = 1'b1;
          slot_nxt  = cmp_idx_r;
          state_nxt = ST_UPD;
        end else if (scan_idx_r < used_r) begin
          key_re       = 1'b1;
          cmp_vld_nxt  = 1'b1;
          cmp_idx_nxt  = scan_idx_r[IDX_W-1:0];
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
        end else begin
          cmp_vld_nxt = 1'b0;
          state_nxt   = ST_MISS;
        end
      end
      ST_UPD: begin
        if (out_free) begin
          win_we        = 1'b1;
          out_valid_nxt = 1'b1;
          out_pay_nxt   = upd_rsp;
          state_nxt     = ST_IDLE;
        end
      end
      ST_MISS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (used_r == FULL_CNT) begin
            out_pay_nxt            = '0;
            out_pay_nxt.table_full = 1'b1;
          end else begin
            key_we      = 1'b1;
            win_we      = 1'b1;
            win_waddr   = used_r[IDX_W-1:0];
            used_nxt    = used_r + CNT_W'(1);
            out_pay_nxt = upd_rsp;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    slot_r     <= slot_nxt;
    out_pay_r  <= out_pay_nxt;
    if (in_fire) begin
      key_r <= in_req.payload.user_key;
      now_r <= in_req.payload.now_seconds;
      lim_r <= in_req.payload.user_limit;
    end
  end

  assign out_rsp.valid   = out_valid_r;
  assign out_rsp.payload = out_pay_r;

endmodule
`default_nettype wire

FILE: hdl/per_key_fixed_window_rate_limiter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_key_fixed_window_rate_limiter
// Per-user fixed-window delivery limiter with an in-order allocated key table.
// ----------------------------------------------------------------------------
// One request is in flight at a time. Its duration grows with E, the number
// of key table entries searched (the match position plus one, or all
// allocated entries for a new user, so at most TABLE_ENTRIES), since the
// linear key search goes through the single read port of the key RAM, one
// entry per cycle. The result sits in an output register and stays there
// until taken; the next request is accepted meanwhile. No clearing pass is
// needed after reset.
// window_seconds resets to 3600 and may be written while the block is idle.
// ----------------------------------------------------------------------------
module per_key_fixed_window_rate_limiter import pkwrl_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  pkwrl_chan_if.sink   in_req,
  pkwrl_chan_if.source out_rsp,
  pkwrl_chan_if.sink   cfg_wr
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int WIN_W = TIME_W + COUNT_BITS + LIMIT_W;

  logic [TIME_W-1:0] window_seconds_r;

  logic             key_we;
  logic [IDX_W-1:0] key_waddr;
  logic [KEY_W-1:0] key_wdata;
  logic             key_re;
  logic [IDX_W-1:0] key_raddr;
  logic [KEY_W-1:0] key_rdata;
  logic             win_we;
  logic [IDX_W-1:0] win_waddr;
  logic [WIN_W-1:0] win_wdata;
  logic             win_re;
  logic [IDX_W-1:0] win_raddr;
  logic [WIN_W-1:0] win_rdata;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_seconds_r <= DEFAULT_WINDOW;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      window_seconds_r <= TIME_W'(cfg_wr.payload);
    end
  end

  pkwrl_ram #(
    .WIDTH  (KEY_W),
    .DEPTH  (TABLE_ENTRIES),
    .ADDR_W (IDX_W)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .re    (key_re),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  pkwrl_ram #(
    .WIDTH  (WIN_W),
    .DEPTH  (TABLE_ENTRIES),
    .ADDR_W (IDX_W)
  ) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata (win_wdata),
    .re    (win_re),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  pkwrl_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .COUNT_BITS    (COUNT_BITS),
    .IDX_W         (IDX_W),
    .WIN_W         (WIN_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_req         (in_req),
    .out_rsp        (out_rsp),
    .window_seconds (window_seconds_r),
    .key_we         (key_we),
    .key_waddr      (key_waddr),
    .key_wdata      (key_wdata),
    .key_re         (key_re),
    .key_raddr      (key_raddr),
    .key_rdata      (key_rdata),
    .win_we         (win_we),
    .win_waddr      (win_waddr),
    .win_wdata      (win_wdata),
    .win_re         (win_re),
    .win_raddr      (win_raddr),
    .win_rdata      (win_rdata)
  );

`ifndef ASSERT_OFF
  a_alloc_writes_both : assert property (@(posedge clk) disable iff (!rst_n)
    key_we |-> (win_we && (win_waddr == key_waddr)))
    else $error("key allocation without window write");

  a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("request accepted while another is in flight");

  a_win_read_busy : assert property (@(posedge clk) disable iff (!rst_n)
    win_re |=> (!in_req.ready && !win_re))
    else $error("window read returned outside an update");

  a_no_scan_on_write : assert property (@(posedge clk) disable iff (!rst_n)
    !(key_re && (key_we || win_we)))
    else $error("key search overlaps a table write");
`endif

endmodule
`default_nettype wire
